FILE: rtl/core/vertex_transform_4x4_assert.svh
// Assertion macros for the vertex transform checker.
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH
// Implication checked on every clock outside reset.
`define VT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define VT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/vt4_pkg.sv
// Shared types, constants and arithmetic helpers for the vertex transform.
`timescale 1ns / 1ps
package vt4_pkg;
  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int Dim      = 4;
  localparam int Lanes    = 3;
  localparam int QuoBits  = 64;
  localparam int DivSteps = WordBits + FracBits;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_DIR   = 2'd2;

  localparam logic signed [WordBits-1:0] WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WordMin = {1'b1, {(WordBits-1){1'b0}}};
  localparam logic signed [WordBits-1:0] OneFx   = WordBits'(1) << FracBits;

  typedef logic signed [WordBits-1:0] word_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic        saturated;
    logic        divide_by_zero;
  } out_item_t;

  // Per-item control that travels with the data down the pipe.
  typedef struct packed {
    logic valid;
    logic persp;
    logic point;
    logic sat;
  } ctl_t;

  // Saturate a wide signed value to the word range.
  function automatic word_t clip(input logic signed [2*WordBits:0] v, output logic f);
    f = 1'b0;
    if (v > $signed({{(WordBits+1){1'b0}}, WordMax})) begin
      f = 1'b1;
      return WordMax;
    end
    if (v < $signed({{(WordBits+1){1'b1}}, WordMin})) begin
      f = 1'b1;
      return WordMin;
    end
    return v[WordBits-1:0];
  endfunction

  // Fixed-point product: truncate toward zero, then saturate.
  function automatic word_t fx_mul(input word_t a, input word_t b, output logic f);
    logic signed [2*WordBits-1:0] p;
    logic [2*WordBits-1:0] m;
    logic signed [2*WordBits:0] s;
    p = a * b;
    m = p[2*WordBits-1] ? (~p + 1'b1) : p;
    m = m >> FracBits;
    s = p[2*WordBits-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    return clip(s, f);
  endfunction

  // Saturating add.
  function automatic word_t sat_add(input word_t a, input word_t b, output logic f);
    logic signed [2*WordBits:0] s;
    s = (2*WordBits+1)'(a) + (2*WordBits+1)'(b);
    return clip(s, f);
  endfunction
endpackage

FILE: rtl/core/vertex_transform_4x4.sv
// Vertex transform top level: three row lanes, a W lane, divide and merge.
// Fully pipelined 4x4 Q16.16 transform: one point or direction transaction is
// accepted every cycle while out_stall is low. Every transform transaction
// takes the same path so order is kept: two lane stages, the divider input
// register, 48 divider stages and the output register. A load writes one
// matrix entry and gives no result; a load is seen by the next point or
// direction. out_stall freezes the whole pipe, and in_stall follows
// out_stall.
`timescale 1ns / 1ps
module vertex_transform_4x4 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vt4_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vt4_pkg::out_item_t out_data
);
  localparam int D = vt4_pkg::DivSteps + 1;

  vt4_pkg::word_t mat_r [16];
  logic           hold, acc_in, xf;
  vt4_pkg::ctl_t  c1_r, c2_r;
  vt4_pkg::ctl_t  cd_r [D];
  vt4_pkg::word_t acc [4];
  logic           lf  [4];
  vt4_pkg::word_t quo [3];
  logic           qf  [3];
  vt4_pkg::word_t rd_r [D][3];
  logic           zw_r [D];
  logic           sat_d, dz;
  vt4_pkg::word_t res [3];

  assign hold     = out_stall;
  assign in_stall = out_stall;
  assign acc_in   = in_valid && !in_stall;
  assign xf = acc_in && (in_data.cmd == vt4_pkg::CMD_POINT || in_data.cmd == vt4_pkg::CMD_DIR);

  // Matrix registers, identity at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= (i % 5 == 0) ? vt4_pkg::OneFx : '0;
      end
    end else if (acc_in && in_data.cmd == vt4_pkg::CMD_LOAD) begin
      mat_r[in_data.entry_index] <= in_data.entry_value;
    end
  end

  // Row lanes: rows 0..2 and the W row.
  for (genvar r = 0; r < 4; r++) begin : g_lane
    vt4_lane u_lane (
      .clk(clk), .en(1'b1),
      .m0(mat_r[r*4]), .m1(mat_r[r*4+1]), .m2(mat_r[r*4+2]), .m3(mat_r[r*4+3]),
      .with_w(in_data.cmd == vt4_pkg::CMD_POINT),
      .vx(in_data.x_in), .vy(in_data.y_in), .vz(in_data.z_in),
      .hold(hold), .acc(acc[r]), .flag(lf[r])
    );
  end

  // Control pipe matching the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
    end else if (!hold) begin
      c1_r.valid <= xf;
      c1_r.persp <= in_data.cmd == vt4_pkg::CMD_POINT && mat_r[14] != '0;
      c1_r.point <= in_data.cmd == vt4_pkg::CMD_POINT;
      c1_r.sat   <= 1'b0;
      c2_r       <= c1_r;
    end
  end

  // Dividers, one for each of the three row lanes.
  for (genvar k = 0; k < 3; k++) begin : g_div
    vt4_div u_div (
      .clk(clk), .hold(hold), .num(acc[k]), .den(acc[3]), .quo(quo[k]), .flag(qf[k])
    );
  end

  // Delay line alongside the divider; the W row counts for every point.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) cd_r[i] <= '0;
    end else if (!hold) begin
      cd_r[0] <= '{valid: c2_r.valid, persp: c2_r.persp, point: c2_r.point,
                   sat: lf[0] | lf[1] | lf[2] | (c2_r.point & lf[3])};
      for (int i = 1; i < D; i++) cd_r[i] <= cd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      rd_r[0][0] <= acc[0];
      rd_r[0][1] <= acc[1];
      rd_r[0][2] <= acc[2];
      zw_r[0]    <= acc[3] == '0;
      for (int i = 1; i < D; i++) begin
        rd_r[i] <= rd_r[i-1];
        zw_r[i] <= zw_r[i-1];
      end
    end
  end

  // Merge stage: pick divided, zero-W or plain results.
  always_comb begin
    sat_d = cd_r[D-1].sat;
    dz    = cd_r[D-1].persp && zw_r[D-1];
    for (int k = 0; k < 3; k++) begin
      if (!cd_r[D-1].persp) begin
        res[k] = rd_r[D-1][k];
      end else if (zw_r[D-1]) begin
        res[k] = rd_r[D-1][k][31] ? vt4_pkg::WordMin :
                 (rd_r[D-1][k] != '0 ? vt4_pkg::WordMax : '0);
      end else begin
        res[k] = quo[k];
        sat_d  = sat_d | qf[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= cd_r[D-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      out_data.x_out          <= res[0];
      out_data.y_out          <= res[1];
      out_data.z_out          <= res[2];
      out_data.saturated      <= sat_d;
      out_data.divide_by_zero <= dz;
    end
  end
endmodule

FILE: rtl/core/vt4_lane.sv
// One row lane: three products, then accumulation with saturation.
`timescale 1ns / 1ps
module vt4_lane (
  input  logic           clk,
  input  logic           en,
  input  vt4_pkg::word_t m0,
  input  vt4_pkg::word_t m1,
  input  vt4_pkg::word_t m2,
  input  vt4_pkg::word_t m3,
  input  logic           with_w,
  input  vt4_pkg::word_t vx,
  input  vt4_pkg::word_t vy,
  input  vt4_pkg::word_t vz,
  input  logic           hold,
  output vt4_pkg::word_t acc,
  output logic           flag
);
  vt4_pkg::word_t p0_r, p1_r, p2_r, p3_r;
  logic           pf_r;
  vt4_pkg::word_t p0_nxt, p1_nxt, p2_nxt;
  logic           f0, f1, f2, a0, a1, a2;
  vt4_pkg::word_t s0, s1, s2, acc_r;
  logic           flag_r;

  // Stage 1: products.
  always_comb begin
    p0_nxt = vt4_pkg::fx_mul(m0, vx, f0);
    p1_nxt = vt4_pkg::fx_mul(m1, vy, f1);
    p2_nxt = vt4_pkg::fx_mul(m2, vz, f2);
  end

  always_ff @(posedge clk) begin
    if (en && !hold) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= with_w ? m3 : '0;
      pf_r <= f0 | f1 | f2;
    end
  end

  // Stage 2: left-to-right accumulation (adding zero never saturates).
  always_comb begin
    s0 = vt4_pkg::sat_add(p0_r, p1_r, a0);
    s1 = vt4_pkg::sat_add(s0, p2_r, a1);
    s2 = vt4_pkg::sat_add(s1, p3_r, a2);
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      acc_r  <= s2;
      flag_r <= pf_r | a0 | a1 | a2;
    end
  end

  assign acc  = acc_r;
  assign flag = flag_r;
endmodule

FILE: rtl/core/vt4_div.sv
// Pipelined restoring divider: one quotient bit per stage, with sign and clip.
`timescale 1ns / 1ps
module vt4_div (
  input  logic           clk,
  input  logic           hold,
  input  vt4_pkg::word_t num,
  input  vt4_pkg::word_t den,
  output vt4_pkg::word_t quo,
  output logic           flag
);
  localparam int N  = vt4_pkg::DivSteps;
  localparam int WB = vt4_pkg::WordBits;

  logic [N-1:0]  rem_r [N+1];
  logic [N-1:0]  q_r   [N+1];
  logic [N-1:0]  nb_r  [N+1];
  logic [WB-1:0] d_r   [N+1];
  logic          neg_r [N+1];
  logic [N-1:0]  rs;

  // Stage 0: magnitudes.
  always_ff @(posedge clk) begin
    if (!hold) begin
      rem_r[0] <= '0;
      q_r[0]   <= '0;
      nb_r[0]  <= N'($unsigned(num[WB-1] ? -num : num)) << vt4_pkg::FracBits;
      d_r[0]   <= WB'(den[WB-1] ? -den : den);
      neg_r[0] <= num[WB-1] ^ den[WB-1];
    end
  end

  // One quotient bit per stage.
  for (genvar i = 0; i < N; i++) begin : g_st
    logic [N:0] r;
    always_comb begin
      r = {rem_r[i], nb_r[i][N-1]};
    end
    always_ff @(posedge clk) begin
      if (!hold) begin
        if (r >= (N+1)'(d_r[i])) begin
          rem_r[i+1] <= N'(r - (N+1)'(d_r[i]));
          q_r[i+1]   <= {q_r[i][N-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= N'(r);
          q_r[i+1]   <= {q_r[i][N-2:0], 1'b0};
        end
        nb_r[i+1]  <= nb_r[i] << 1;
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // Sign and clip.
  always_comb begin
    logic signed [2*WB:0] s;
    rs = q_r[N];
    s  = neg_r[N] ? -$signed((2*WB+1)'(rs)) : $signed((2*WB+1)'(rs));
    quo = vt4_pkg::clip(s, flag);
  end
endmodule

FILE: rtl/core/vt4_checker.sv
// Port checker for the vertex transform, bound to the top level.
`timescale 1ns / 1ps
`include "vertex_transform_4x4_assert.svh"
module vt4_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input vt4_pkg::out_item_t out_data
);
  `VT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `VT_ASSERT_NEXT(a_data_hold, clk, rst_n, out_valid && out_stall, $stable(out_data))
  `VT_ASSERT_IMPL(a_stall_follow, clk, rst_n, out_stall, in_stall)
  // A zero W leaves only full scale or zero on x.
  `VT_ASSERT_IMPL(a_dz_range, clk, rst_n, out_valid && out_data.divide_by_zero, out_data.x_out == vt4_pkg::WordMax || out_data.x_out == vt4_pkg::WordMin || out_data.x_out == '0)
endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

FILE: tb/testbench.sv
// Self-checking testbench for the 4x4 fixed-point vertex transform.
`timescale 1ns / 1ps
module testbench;
  localparam int LatencyCycles = 60;
  localparam logic [1:0] CmdUnused = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  vt4_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  vt4_pkg::out_item_t out_data;

  vertex_transform_4x4 i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow matrix and queues
  logic signed [63:0] shadow_matrix [16];
  vt4_pkg::in_item_t  pending_items [$];
  vt4_pkg::out_item_t expected_vectors [$];
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_off_cycles;

  localparam logic signed [63:0] WMax = 64'sd2147483647;
  localparam logic signed [63:0] WMin = -64'sd2147483648;

  // Clip a wide value to the word range
  function automatic logic signed [63:0] clip_word(input logic signed [129:0] v,
                                                   inout bit flag);
    if (v > WMax) begin
      flag = 1;
      return WMax;
    end
    if (v < WMin) begin
      flag = 1;
      return WMin;
    end
    return v[63:0];
  endfunction

  // Product, truncated toward zero before clipping
  function automatic logic signed [63:0] mul_fx(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                inout bit flag);
    logic signed [129:0] p;
    p = 130'(a) * 130'(b);
    if (p < 0) p = -((-p) >>> vt4_pkg::FracBits);
    else p = p >>> vt4_pkg::FracBits;
    return clip_word(p, flag);
  endfunction

  // Quotient (x << frac) / w, truncated toward zero
  function automatic logic signed [63:0] div_fx(input logic signed [63:0] x,
                                                input logic signed [63:0] w,
                                                inout bit flag);
    logic signed [129:0] n;
    logic signed [129:0] q;
    n = 130'(x) <<< vt4_pkg::FracBits;
    q = n / 130'(w);
    return clip_word(q, flag);
  endfunction

  function automatic logic signed [63:0] row_sum(input int row,
                                                 input logic signed [63:0] v [3],
                                                 input bit with_w, inout bit flag);
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    acc = mul_fx(shadow_matrix[row*4], v[0], flag);
    for (int c = 1; c < 3; c++) begin
      prod = mul_fx(shadow_matrix[row*4+c], v[c], flag);
      acc = clip_word(130'(acc) + 130'(prod), flag);
    end
    if (with_w) acc = clip_word(130'(acc) + 130'(shadow_matrix[row*4+3]), flag);
    return acc;
  endfunction

  // Apply one transaction to the shadow matrix and queue any expected vector
  task automatic predict_transform(input vt4_pkg::in_item_t it);
    logic signed [63:0] v [3];
    logic signed [63:0] r [3];
    logic signed [63:0] w;
    bit sat;
    vt4_pkg::out_item_t res;
    sat = 0;
    if (it.cmd == vt4_pkg::CMD_LOAD) begin
      shadow_matrix[it.entry_index] = 64'(it.entry_value);
      return;
    end
    if (it.cmd != vt4_pkg::CMD_POINT && it.cmd != vt4_pkg::CMD_DIR) return;
    v[0] = 64'(it.x_in);
    v[1] = 64'(it.y_in);
    v[2] = 64'(it.z_in);
    res.divide_by_zero = 0;
    if (it.cmd == vt4_pkg::CMD_POINT) begin
      for (int k = 0; k < 3; k++) r[k] = row_sum(k, v, 1, sat);
      w = row_sum(3, v, 1, sat);
      if (shadow_matrix[14] != 0) begin
        if (w == 0) begin
          res.divide_by_zero = 1;
          for (int k = 0; k < 3; k++) r[k] = r[k] > 0 ? WMax : (r[k] < 0 ? WMin : 0);
        end else begin
          for (int k = 0; k < 3; k++) r[k] = div_fx(r[k], w, sat);
        end
      end
    end else begin
      for (int k = 0; k < 3; k++) r[k] = row_sum(k, v, 0, sat);
    end
    res.x_out = r[0][31:0];
    res.y_out = r[1][31:0];
    res.z_out = r[2][31:0];
    res.saturated = sat;
    expected_vectors.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      3: return 32'($signed($urandom_range(0, 200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic vt4_pkg::in_item_t make_item(input logic [1:0] cmd, input int idx,
                                                  input logic [31:0] val,
                                                  input logic [31:0] x,
                                                  input logic [31:0] y,
                                                  input logic [31:0] z);
    vt4_pkg::in_item_t it;
    it.cmd = cmd;
    it.entry_index = 4'(idx);
    it.entry_value = val;
    it.x_in = x;
    it.y_in = y;
    it.z_in = z;
    return it;
  endfunction

  function automatic vt4_pkg::in_item_t rand_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20)
      return make_item(vt4_pkg::CMD_LOAD, $urandom_range(0, 15), rand_word(), $urandom,
                       $urandom, $urandom);
    if (sel < 23)
      return make_item(CmdUnused, $urandom, $urandom, $urandom, $urandom, $urandom);
    return make_item(sel < 65 ? vt4_pkg::CMD_POINT : vt4_pkg::CMD_DIR, $urandom, $urandom,
                     rand_word(), rand_word(), rand_word());
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: offer the next pending transaction
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        in_valid <= 1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Acceptance: predict on each accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_transform(in_data);
  end

  // Receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    vt4_pkg::out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vectors.size() == 0) begin
        report_mismatch("unexpected result", out_data.x_out, '0);
      end else begin
        exp_res = expected_vectors.pop_front();
        if (out_data.x_out !== exp_res.x_out)
          report_mismatch("x_out", out_data.x_out, exp_res.x_out);
        if (out_data.y_out !== exp_res.y_out)
          report_mismatch("y_out", out_data.y_out, exp_res.y_out);
        if (out_data.z_out !== exp_res.z_out)
          report_mismatch("z_out", out_data.z_out, exp_res.z_out);
        if (out_data.saturated !== exp_res.saturated)
          report_mismatch("saturated", 32'(out_data.saturated), 32'(exp_res.saturated));
        if (out_data.divide_by_zero !== exp_res.divide_by_zero)
          report_mismatch("divide_by_zero", 32'(out_data.divide_by_zero),
                          32'(exp_res.divide_by_zero));
      end
    end
  end

  task automatic drain_queue();
    while (pending_items.size() > 0 || in_valid) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int phase_idle [4];
    int phase_stall [4];
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    in_data = '0;
    for (int i = 0; i < 16; i++)
      shadow_matrix[i] = (i % 5 == 0) ? 64'(vt4_pkg::OneFx) : 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: identity, extremes, loads of every entry, perspective cases
    pending_items.push_back(make_item(vt4_pkg::CMD_POINT, 0, 0, 32'h00010000,
                                      32'hffff0000, 0));
    pending_items.push_back(make_item(vt4_pkg::CMD_DIR, 15, 32'hffffffff, 32'h7fffffff,
                                      32'h80000000, 32'hffffffff));
    pending_items.push_back(make_item(CmdUnused, 15, 32'hffffffff, 1, 2, 3));
    pending_items.push_back(make_item(vt4_pkg::CMD_LOAD, 0, 32'h7fffffff, 0, 0, 0));
    pending_items.push_back(make_item(vt4_pkg::CMD_LOAD, 5, 32'h80000000, 0, 0, 0));
    pending_items.push_back(make_item(vt4_pkg::CMD_POINT, 0, 0, 32'h7fffffff, 32'h7fffffff,
                                      32'h80000000));
    pending_items.push_back(make_item(vt4_pkg::CMD_LOAD, 3, 32'h7fffffff, 0, 0, 0));
    pending_items.push_back(make_item(vt4_pkg::CMD_POINT, 0, 0, 32'h00020000,
                                      32'h00010000, 1));
    pending_items.push_back(make_item(vt4_pkg::CMD_LOAD, 14, 32'h00010000, 0, 0, 0));
    pending_items.push_back(make_item(vt4_pkg::CMD_LOAD, 15, 0, 0, 0, 0));
    // W = z here; zero z gives a divide by zero
    pending_items.push_back(make_item(vt4_pkg::CMD_POINT, 0, 0, 32'h00030000,
                                      32'hfffd0000, 0));
    pending_items.push_back(make_item(vt4_pkg::CMD_POINT, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(vt4_pkg::CMD_POINT, 0, 0, 32'h00030000, 5,
                                      32'h00020000));
    pending_items.push_back(make_item(vt4_pkg::CMD_POINT, 0, 0, 32'h7fffffff, 1, 1));
    pending_items.push_back(make_item(vt4_pkg::CMD_DIR, 0, 0, 32'h00030000, 0, 0));
    for (int i = 0; i < 16; i++)
      pending_items.push_back(make_item(vt4_pkg::CMD_LOAD, i,
                                        (i % 5 == 0) ? 32'h00010000 : 0, 0, 0, 0));
    drain_queue();

    // Random phases with different idle and stall mixes
    phase_idle = '{0, 65, 0, 28};
    phase_stall = '{0, 0, 65, 28};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      if (p == 0) hold_off_cycles = 400;
      for (int n = 0; n < 290; n++) pending_items.push_back(rand_item());
      drain_queue();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (expected_vectors.size() > 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_vectors.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
